// ===== rtl/xymu_pkg.sv =====
// ----------------------------------------------------------------------------
// xymu_pkg
// shared types, constants and lookup tables for the xy model update block
// ----------------------------------------------------------------------------
package xymu_pkg;

  localparam int unsigned COS_BITS = 10;
  localparam int unsigned COS_LEN  = 1 << COS_BITS;
  localparam int unsigned EXP_LEN  = 768;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  site_row;
    logic [8:0]  site_col;
    logic [15:0] new_angle;
    logic [15:0] accept_draw;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] site_angle;
    logic        accepted;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CENTER,
    ST_RD_NBR,
    ST_SUM,
    ST_PROB,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef logic [COS_LEN-1:0][15:0] cos_tab_t;
  typedef logic [EXP_LEN-1:0][16:0] exp_tab_t;

  // quarter-wave cosine in q1.14, truncating taylor steps
  function automatic logic signed [15:0] quarter_cos(input int k);
    longint one;
    longint x;
    longint x2;
    longint t;
    begin
      one = longint'(1) <<< 30;
      x   = longint'(k) * 6588397;
      x2  = (x * x) >>> 30;
      t   = one - x2 / 56;
      t   = one - ((x2 * t) >>> 30) / 30;
      t   = one - ((x2 * t) >>> 30) / 12;
      t   = one - ((x2 * t) >>> 30) / 2;
      if (t < 0) t = 0;
      quarter_cos = 16'((t + (longint'(1) <<< 15)) >>> 16);
    end
  endfunction

  // full-wave table built from the quarter wave by symmetry
  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    int       q;
    begin
      for (int i = 0; i < COS_LEN; i++) begin
        q = i & 255;
        case (i >> 8)
          0:       t[i] = quarter_cos(q);
          1:       t[i] = -quarter_cos(256 - q);
          2:       t[i] = -quarter_cos(q);
          default: t[i] = quarter_cos(256 - q);
        endcase
      end
      build_cos = t;
    end
  endfunction

  // exp(-k/64) in q1.16 built by repeated q32 multiplication
  function automatic exp_tab_t build_exp();
    exp_tab_t    t;
    logic [63:0] e;
    begin
      e = 64'd1 << 32;
      for (int i = 0; i < EXP_LEN; i++) begin
        t[i] = 17'((e + 64'd32768) >> 16);
        e = (e * 64'd4228380000 + (64'd1 << 31)) >> 32;
      end
      build_exp = t;
    end
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();
  localparam exp_tab_t EXP_TAB = build_exp();

  function automatic logic signed [15:0] cos_lut(input logic [COS_BITS-1:0] idx);
    cos_lut = signed'(COS_TAB[idx]);
  endfunction

  function automatic logic [16:0] exp_lut(input logic [9:0] k);
    exp_lut = (k >= 10'(EXP_LEN)) ? 17'd0 : EXP_TAB[k];
  endfunction

endpackage

// ===== rtl/xy_model_metropolis_update.sv =====
// ----------------------------------------------------------------------------
// xy_model_metropolis_update
// metropolis step of the xy model on a periodic lattice held in one ram
// ----------------------------------------------------------------------------
// A load or a read runs through ST_RD_CENTER and ST_DONE; an update runs
// through ST_RD_CENTER, ST_RD_NBR, ST_SUM, ST_PROB, ST_DECIDE and ST_DONE.
// The single lattice ram port fetches the site and its four neighbours one
// per cycle, then the beta product, the probability lookup and the accept
// decision follow. An update writes back in ST_DONE, where the result is
// registered. busy is high from the accepting edge through the result cycle,
// so the next command is taken at the earliest in the cycle after the strobe.
// out_valid is a one-cycle strobe the receiver cannot stall. cfg_ready is
// high while idle. Unloaded sites read undefined values.
module xy_model_metropolis_update #(
  parameter int unsigned SIDE       = 512,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  xymu_pkg::in_beat_t    in_beat,
  output logic                  out_valid,
  output xymu_pkg::out_beat_t   out_beat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);
  localparam int unsigned CW = $clog2(SIDE);
  localparam int unsigned AW = $clog2(SIDE * SIDE);
  // floor reciprocal of side for the coordinate fold
  localparam int unsigned RM = (1 << 18) / SIDE;

  // control
  xymu_pkg::state_t state_r, state_nxt;
  logic [1:0]       nidx_r, nidx_nxt;
  logic [15:0]      beta_r;

  // item registers
  logic [1:0]            op_r;
  logic [CW-1:0]         row_r, col_r;
  logic [ANGLE_BITS-1:0] na_r;
  logic [15:0]           draw_r;
  logic [ANGLE_BITS-1:0] old_r;
  logic [33:0]           prod_r;
  logic                  acc_r;
  logic [16:0]           prob_r;
  logic [15:0]           oangle_r;
  logic                  oacc_r;
  logic                  ovalid_r;

  // ram
  logic                  we;
  logic [AW-1:0]         addr;
  logic [ANGLE_BITS-1:0] wdata, rdata;

  logic                  e_clr, e_add;
  logic signed [17:0]    old_sum, new_sum;
  logic [17:0]           diff;

  // coordinate reduction modulo side: reciprocal estimate, one correction
  function automatic logic [CW-1:0] fold(input logic [8:0] v);
    logic [27:0] p;
    logic [9:0]  q;
    logic [22:0] rem;
    p   = 28'(v) * 28'(RM);
    q   = p[27:18];
    rem = 23'(v) - 23'(q) * 23'(SIDE);
    if (rem >= 23'(SIDE)) rem = rem - 23'(SIDE);
    fold = CW'(rem);
  endfunction

  function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
    inc = (v == CW'(SIDE - 1)) ? '0 : v + 1'b1;
  endfunction
  function automatic logic [CW-1:0] dec(input logic [CW-1:0] v);
    dec = (v == '0) ? CW'(SIDE - 1) : v - 1'b1;
  endfunction
  // row-major lattice address
  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    site_addr = AW'(r) * AW'(SIDE) + AW'(c);
  endfunction

  logic [CW-1:0] in_row, in_col;
  assign in_row = fold(in_beat.site_row);
  assign in_col = fold(in_beat.site_col);

  xymu_ram #(.WIDTH(ANGLE_BITS), .DEPTH(SIDE * SIDE)) u_ram (
    .clk, .we, .addr, .wdata, .rdata
  );

  xymu_energy #(.ANGLE_BITS(ANGLE_BITS)) u_energy (
    .clk, .clr(e_clr), .add(e_add),
    .old_angle(old_r), .new_angle(na_r), .nbr_angle(rdata),
    .old_sum, .new_sum
  );

  assign diff = 18'(old_sum - new_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= xymu_pkg::ST_IDLE;
      nidx_r   <= '0;
      beta_r   <= 16'd256;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      nidx_r   <= nidx_nxt;
      ovalid_r <= (state_r == xymu_pkg::ST_DONE);
      if (cfg_valid && cfg_ready) beta_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_beat.op;
      row_r  <= in_row;
      col_r  <= in_col;
      na_r   <= ANGLE_BITS'(in_beat.new_angle);
      draw_r <= in_beat.accept_draw;
    end
    // center data is back in the first cycle after the accept
    if (state_r == xymu_pkg::ST_RD_CENTER) old_r <= rdata;
    if (state_r == xymu_pkg::ST_SUM) prod_r <= 34'(diff) * 34'(beta_r);
    if (state_r == xymu_pkg::ST_PROB)
      prob_r <= (prod_r[33:16] >= 18'(xymu_pkg::EXP_LEN)) ? 17'd0
                : xymu_pkg::exp_lut(prod_r[25:16]);
    if (state_r == xymu_pkg::ST_SUM) acc_r <= (new_sum >= old_sum);
    if (state_r == xymu_pkg::ST_DECIDE && !acc_r) acc_r <= ({1'b0, draw_r} < prob_r);
    if (state_r == xymu_pkg::ST_DONE) begin
      unique case (op_r)
        xymu_pkg::OP_LOAD: begin
          oangle_r <= 16'(na_r);
          oacc_r   <= 1'b1;
        end
        xymu_pkg::OP_UPDATE: begin
          oangle_r <= acc_r ? 16'(na_r) : 16'(old_r);
          oacc_r   <= acc_r;
        end
        default: begin
          oangle_r <= 16'(rdata);
          oacc_r   <= 1'b0;
        end
      endcase
    end
  end

  // sequencer: address, write and accumulate control
  always_comb begin
    state_nxt = state_r;
    nidx_nxt  = nidx_r;
    we        = 1'b0;
    addr      = site_addr(row_r, col_r);
    wdata     = na_r;
    e_clr     = 1'b0;
    e_add     = 1'b0;
    unique case (state_r)
      xymu_pkg::ST_IDLE: begin
        addr  = site_addr(in_row, in_col);
        e_clr = 1'b1;
        if (start && !busy) begin
          state_nxt = xymu_pkg::ST_RD_CENTER;
          nidx_nxt  = '0;
        end
      end
      xymu_pkg::ST_RD_CENTER: begin
        // center read issued in idle; loads write here
        if (op_r == xymu_pkg::OP_LOAD) begin
          we        = 1'b1;
          state_nxt = xymu_pkg::ST_DONE;
        end else if (op_r == xymu_pkg::OP_UPDATE) begin
          addr      = site_addr(inc(row_r), col_r);
          state_nxt = xymu_pkg::ST_RD_NBR;
        end else begin
          state_nxt = xymu_pkg::ST_DONE;
        end
      end
      xymu_pkg::ST_RD_NBR: begin
        // nidx 0..3: data of neighbour nidx back, next neighbour address out (center at 3)
        unique case (nidx_r)
          2'd0:    addr = site_addr(dec(row_r), col_r);
          2'd1:    addr = site_addr(row_r, inc(col_r));
          2'd2:    addr = site_addr(row_r, dec(col_r));
          default: addr = site_addr(row_r, col_r);
        endcase
        e_add    = 1'b1;
        nidx_nxt = nidx_r + 1'b1;
        if (nidx_r == 2'd3) state_nxt = xymu_pkg::ST_SUM;
      end
      xymu_pkg::ST_SUM:    state_nxt = xymu_pkg::ST_PROB;
      xymu_pkg::ST_PROB:   state_nxt = xymu_pkg::ST_DECIDE;
      xymu_pkg::ST_DECIDE: state_nxt = xymu_pkg::ST_DONE;
      xymu_pkg::ST_DONE: begin
        if (op_r == xymu_pkg::OP_UPDATE) we = acc_r;
        state_nxt = xymu_pkg::ST_IDLE;
      end
      default: state_nxt = xymu_pkg::ST_IDLE;
    endcase
  end

  assign busy              = (state_r != xymu_pkg::ST_IDLE) || ovalid_r;
  assign cfg_ready         = !busy;
  assign out_valid         = ovalid_r;
  assign out_beat.site_angle = oangle_r;
  assign out_beat.accepted   = oacc_r;
endmodule

// ===== rtl/xymu_ram.sv =====
// ----------------------------------------------------------------------------
// xymu_ram
// generic single-port ram with a registered read
// ----------------------------------------------------------------------------
module xymu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/xymu_energy.sv =====
// ----------------------------------------------------------------------------
// xymu_energy
// accumulates old and new cosine sums, one neighbour per cycle while add is high
// ----------------------------------------------------------------------------
module xymu_energy #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  clr,
  input  logic                  add,
  input  logic [ANGLE_BITS-1:0] old_angle,
  input  logic [ANGLE_BITS-1:0] new_angle,
  input  logic [ANGLE_BITS-1:0] nbr_angle,
  output logic signed [17:0]    old_sum,
  output logic signed [17:0]    new_sum
);
  localparam int unsigned CB = xymu_pkg::COS_BITS;

  logic [ANGLE_BITS-1:0]          d_old, d_new;
  logic [CB-1:0]                  i_old, i_new;
  logic signed [17:0]             old_sum_r, new_sum_r;

  assign d_old = old_angle - nbr_angle;
  assign d_new = new_angle - nbr_angle;

  // table index is the top cos bits of the difference
  generate
    if (ANGLE_BITS >= CB) begin : g_shr
      assign i_old = CB'(d_old >> (ANGLE_BITS - CB));
      assign i_new = CB'(d_new >> (ANGLE_BITS - CB));
    end else begin : g_shl
      assign i_old = CB'(d_old) << (CB - ANGLE_BITS);
      assign i_new = CB'(d_new) << (CB - ANGLE_BITS);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (clr) begin
      old_sum_r <= '0;
      new_sum_r <= '0;
    end else if (add) begin
      old_sum_r <= old_sum_r + 18'(xymu_pkg::cos_lut(i_old));
      new_sum_r <= new_sum_r + 18'(xymu_pkg::cos_lut(i_new));
    end
  end

  assign old_sum = old_sum_r;
  assign new_sum = new_sum_r;
endmodule

// ===== rtl/xymu_checker.sv =====
// ----------------------------------------------------------------------------
// xymu_checker
// port-level checks for the xy model update block
// ----------------------------------------------------------------------------
module xymu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input xymu_pkg::out_beat_t out_beat,
  input logic                cfg_ready
);
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");
  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("config accepted while busy");
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_beat)) else $error("result beat has unknown bits");
endmodule

bind xy_model_metropolis_update xymu_checker u_xymu_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_beat, .cfg_ready
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for xy_model_metropolis_update
// drives load, update, read and spare commands at corner and random lattice
// sites, predicts every result from a local lattice copy and fixed-point
// cosine and exponential tables, and checks each result strobe in order
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATTICE_SIDE = 512;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  xymu_pkg::in_beat_t   in_beat;
  logic       out_valid;
  xymu_pkg::out_beat_t  out_beat;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [15:0] cfg_data;

  xy_model_metropolis_update dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // local copy of the lattice, the coupling and the lookup tables
  logic [15:0] lattice_angle [int];
  logic [15:0] beta_q8_8;
  int          cos_q14 [1024];
  logic [16:0] boltzmann_q16 [768];

  xymu_pkg::in_beat_t  cmd_queue [$];
  xymu_pkg::out_beat_t site_result_q [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        gap_left;

  // sites that the stimulus generator knows to be loaded
  bit        gen_loaded [int];
  int        hot_sites [$];

  // truncating taylor series for one quarter wave, rounded to q1.14
  function automatic int quarter_wave(int k);
    longint one;
    longint x;
    longint x2;
    longint t;
    one = longint'(1) <<< 30;
    x   = longint'(k) * 6588397;
    x2  = (x * x) >>> 30;
    t   = one - x2 / 56;
    t   = one - ((x2 * t) >>> 30) / 30;
    t   = one - ((x2 * t) >>> 30) / 12;
    t   = one - ((x2 * t) >>> 30) / 2;
    if (t < 0) t = 0;
    return int'((t + (longint'(1) <<< 15)) >>> 16);
  endfunction

  function automatic int site_key(int r, int c);
    return (r % LATTICE_SIDE) * LATTICE_SIDE + (c % LATTICE_SIDE);
  endfunction

  function automatic int coupling(logic [15:0] a, logic [15:0] b);
    logic [15:0] diff;
    diff = a - b;
    return cos_q14[diff[15:6]];
  endfunction

  // one metropolis step against the local lattice copy
  function automatic xymu_pkg::out_beat_t metropolis_step(xymu_pkg::in_beat_t b);
    xymu_pkg::out_beat_t res;
    int          r;
    int          c;
    int          here;
    int          nbr [4];
    logic [15:0] old_angle;
    int          old_sum;
    int          new_sum;
    longint unsigned y;
    longint unsigned k;
    logic [16:0] p;
    logic        acc;
    r = int'(b.site_row);
    c = int'(b.site_col);
    here = site_key(r, c);
    acc = 1'b0;
    case (xymu_pkg::op_t'(b.op))
      xymu_pkg::OP_LOAD: begin
        lattice_angle[here] = b.new_angle;
        acc = 1'b1;
      end
      xymu_pkg::OP_UPDATE: begin
        old_angle = lattice_angle[here];
        nbr[0] = site_key(r + 1, c);
        nbr[1] = site_key(r + LATTICE_SIDE - 1, c);
        nbr[2] = site_key(r, c + 1);
        nbr[3] = site_key(r, c + LATTICE_SIDE - 1);
        old_sum = 0;
        new_sum = 0;
        for (int i = 0; i < 4; i++) begin
          old_sum += coupling(old_angle, lattice_angle[nbr[i]]);
          new_sum += coupling(b.new_angle, lattice_angle[nbr[i]]);
        end
        if (new_sum >= old_sum) begin
          acc = 1'b1;
        end else begin
          y = longint'(unsigned'(old_sum - new_sum)) * beta_q8_8;
          k = y >> 16;
          p = (k < 768) ? boltzmann_q16[k] : 17'd0;
          acc = ({1'b0, b.accept_draw} < p);
        end
        if (acc) lattice_angle[here] = b.new_angle;
      end
      default: ;
    endcase
    res.site_angle = lattice_angle[here];
    res.accepted   = acc;
    return res;
  endfunction

  // mostly back to back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // command driver: present the next queued beat once the gap has run out
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
      in_beat  <= '0;
    end else begin
      if (start && !busy) begin
        site_result_q.push_back(metropolis_step(in_beat));
        gap_left <= pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0 && !(start && !busy)) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (start && !busy && gap_left == 0 && cmd_queue.size() == 0) begin
          start <= 1'b0;
        end else if ((start && !busy) || gap_left == 0) begin
          if (start && !busy) begin
            start <= 1'b0;
          end else if (cmd_queue.size() != 0) begin
            in_beat <= cmd_queue.pop_front();
            start   <= 1'b1;
          end
        end
      end
    end
  end

  // coupling register write: beta takes effect at the handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      beta_q8_8 <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      beta_q8_8 <= cfg_data;
    end
  end

  // result monitor: every strobe must match the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (site_result_q.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        if (out_beat.site_angle !== site_result_q[0].site_angle) begin
          $error("site_angle expected %h got %h",
                 site_result_q[0].site_angle, out_beat.site_angle);
          fail_count++;
        end
        if (out_beat.accepted !== site_result_q[0].accepted) begin
          $error("accepted expected %b got %b",
                 site_result_q[0].accepted, out_beat.accepted);
          fail_count++;
        end
        void'(site_result_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL xy_model_metropolis_update");
      $finish;
    end
  end

  task automatic push_cmd(xymu_pkg::op_t op, int r, int c, logic [15:0] ang,
                          logic [15:0] draw);
    xymu_pkg::in_beat_t b;
    b.op          = op;
    b.site_row    = 9'(r);
    b.site_col    = 9'(c);
    b.new_angle   = ang;
    b.accept_draw = draw;
    cmd_queue.push_back(b);
    if (op == xymu_pkg::OP_LOAD) gen_loaded[site_key(r, c)] = 1'b1;
  endtask

  // update at a site, loading the site and any neighbour not yet written
  task automatic push_update(int r, int c, logic [15:0] ang, logic [15:0] draw);
    int rr [5];
    int cc [5];
    rr = '{r, (r + 1) % LATTICE_SIDE, (r + LATTICE_SIDE - 1) % LATTICE_SIDE, r, r};
    cc = '{c, c, c, (c + 1) % LATTICE_SIDE, (c + LATTICE_SIDE - 1) % LATTICE_SIDE};
    for (int i = 0; i < 5; i++)
      if (!gen_loaded.exists(site_key(rr[i], cc[i])))
        push_cmd(xymu_pkg::OP_LOAD, rr[i], cc[i], 16'($urandom), 16'($urandom));
    push_cmd(xymu_pkg::OP_UPDATE, r, c, ang, draw);
    hot_sites.push_back(site_key(r, c));
  endtask

  // wait until the block is idle and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || start || site_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_beta(logic [15:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_draw();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_phase(int count);
    int roll;
    int key;
    int r;
    int c;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        if (hot_sites.size() != 0 && $urandom_range(0, 9) < 7) begin
          key = hot_sites[$urandom_range(0, hot_sites.size() - 1)];
          r = key / LATTICE_SIDE;
          c = key % LATTICE_SIDE;
        end else begin
          r = $urandom_range(0, LATTICE_SIDE - 1);
          c = $urandom_range(0, LATTICE_SIDE - 1);
        end
        push_update(r, c, 16'($urandom), pick_draw());
      end else if (roll < 95 && hot_sites.size() != 0) begin
        key = hot_sites[$urandom_range(0, hot_sites.size() - 1)];
        r = key / LATTICE_SIDE;
        c = key % LATTICE_SIDE;
        if (roll < 75)
          push_cmd(xymu_pkg::OP_READ, r, c, 16'($urandom), 16'($urandom));
        else if (roll < 90)
          push_cmd(xymu_pkg::OP_LOAD, r, c, 16'($urandom), 16'($urandom));
        else
          push_cmd(xymu_pkg::OP_SPARE, r, c, 16'($urandom), 16'($urandom));
      end else begin
        push_cmd(xymu_pkg::OP_LOAD, $urandom_range(0, LATTICE_SIDE - 1),
                 $urandom_range(0, LATTICE_SIDE - 1), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    int edges [4];
    logic [63:0] e;
    logic [15:0] betas [7];
    for (int i = 0; i < 1024; i++) begin
      case (i >> 8)
        0:       cos_q14[i] = quarter_wave(i & 255);
        1:       cos_q14[i] = -quarter_wave(256 - (i & 255));
        2:       cos_q14[i] = -quarter_wave(i & 255);
        default: cos_q14[i] = quarter_wave(256 - (i & 255));
      endcase
    end
    e = 64'd1 << 32;
    for (int i = 0; i < 768; i++) begin
      boltzmann_q16[i] = 17'((e + 64'd32768) >> 16);
      e = (e * 64'd4228380000 + (64'd1 << 31)) >> 32;
    end
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 16'd0;

    // directed: sites near the torus corners, so corner updates wrap both ways
    edges = '{0, 1, 510, 511};
    foreach (edges[i])
      foreach (edges[j])
        push_cmd(xymu_pkg::OP_LOAD, edges[i], edges[j],
                 (i == 0 && j == 0) ? 16'h0000 :
                 (i == 3 && j == 3) ? 16'hFFFF : 16'($urandom), 16'($urandom));
    push_cmd(xymu_pkg::OP_READ, 0, 0, 16'hFFFF, 16'hFFFF);
    push_cmd(xymu_pkg::OP_SPARE, 511, 511, 16'h0000, 16'h0000);
    push_update(0, 0, 16'hFFFF, 16'h0000);
    push_update(511, 511, 16'h0000, 16'hFFFF);
    push_update(0, 511, 16'h8000, 16'hFFFF);
    push_update(511, 0, 16'($urandom), 16'h0000);
    // proposing the stored angle gives equal sums and must be taken
    push_cmd(xymu_pkg::OP_LOAD, 0, 0, 16'h1234, 16'h0000);
    push_update(0, 0, 16'h1234, 16'hFFFF);
    push_update(0, 0, 16'h9234, 16'hFFFF);
    push_cmd(xymu_pkg::OP_READ, 0, 511, 16'h0000, 16'h0000);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // phases at several couplings, from infinite temperature to very cold
    betas = '{16'd0, 16'hFFFF, 16'd64, 16'd1024, 16'd16, 16'd256, 16'($urandom)};
    foreach (betas[i]) begin
      write_beta(betas[i]);
      random_phase(88);
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS xy_model_metropolis_update");
    end else begin
      $display("FAIL xy_model_metropolis_update");
    end
    $finish;
  end

endmodule
